/* src/bbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_pkg - shared types and constants for the 3x3 RGB box blur
// Pixel and control types, register codes, field widths and the reciprocal
// used for the exact divide by nine.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int DEFAULT_MAX_WIDTH = 1024;

	localparam int CHAN_W     = 8;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 13;
	localparam int BLUR_W     = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int ROW_W      = 14;
	localparam int TAPS       = 9;

	// floor(s / 9) == (s * RECIP) >> RECIP_SHIFT for every 3x3 sum of bytes
	localparam int SUM_W       = 12;
	localparam int RECIP_SHIFT = 15;
	localparam logic [SUM_W-1:0] RECIP = 12'd3641;

	localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd1024;
	localparam logic [IMG_H_W-1:0] IMG_H_RESET = 13'd1024;
	localparam logic [BLUR_W-1:0]  BLUR_RESET  = 13'd512;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_BLUR_ROWS    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic valid;
		logic blur;
		logic last;
	} ctrl_t;

endpackage
`default_nettype wire

/* src/box_blur_3x3_rgb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb - 3x3 mean blur on an RGB raster stream
// Three channel lanes share one 3x3 window fed from a two-row line store;
// the merge stage forms the output pixel.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_stall    operation, red_in, green_in, blue_in
//   out       source     out_valid/out_stall  red_out, green_out, blue_out, frame_end
//   cfg       sink       cfg_wr_en            cfg_index, cfg_data
//
// One item per clock sustained while out is not stalled; a result passes
// through the line store read and stage 1 registers at the transfer edge,
// then the lane sum registers, then the merge output register.
// A stall on out fills the three stages before in_stall rises.
// Reset clears positions, window and valid flags; the line store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH = bbr_pkg::DEFAULT_MAX_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           operation,
	input  wire logic [bbr_pkg::CHAN_W-1:0]     red_in,
	input  wire logic [bbr_pkg::CHAN_W-1:0]     green_in,
	input  wire logic [bbr_pkg::CHAN_W-1:0]     blue_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [bbr_pkg::CHAN_W-1:0]     red_out,
	output logic      [bbr_pkg::CHAN_W-1:0]     green_out,
	output logic      [bbr_pkg::CHAN_W-1:0]     blue_out,
	output logic                                frame_end,
	input  wire logic                           cfg_wr_en,
	input  wire logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bbr_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > IMG_W_W) ? WW : IMG_W_W;

	// configuration
	logic [IMG_W_W-1:0] image_width_q;
	logic [IMG_H_W-1:0] image_height_q;
	logic [BLUR_W-1:0]  blur_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_W_RESET;
			image_height_q <= IMG_H_RESET;
			blur_rows_q    <= BLUR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_W-1:0];
				CFG_BLUR_ROWS:    blur_rows_q    <= cfg_data[BLUR_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position and item decode
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [EW-1:0]    w_eff;
	logic [EW-1:0]    img_w_x;
	logic [ROW_W-1:0] h_eff;
	logic [ROW_W-1:0] blur_x;
	logic             wrap;
	logic [CW-1:0]    col_now;
	logic [ROW_W-1:0] row_now;
	logic [ROW_W-1:0] row_m1;
	logic [ROW_W-1:0] row_m2;
	logic             in_frame;
	logic             ignore;
	logic             col_zero;
	logic             row_ge1;
	logic             row_ge2;
	logic             eor;
	logic             eor_last;
	logic             blur_e;
	logic             blur_c;
	logic             cur;
	logic             top_ok;
	logic             mid_ok;
	logic             end_row;
	pixel_t           pix;

	assign img_w_x = EW'(image_width_q);
	assign w_eff   = (image_width_q == '0) ? EW'(1) :
	                 ((img_w_x > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : img_w_x);
	assign h_eff   = (image_height_q == '0) ? ROW_W'(1) : ROW_W'(image_height_q);
	assign blur_x  = ROW_W'(blur_rows_q);

	assign wrap     = EW'(col_q) >= w_eff;
	assign col_now  = wrap ? '0 : col_q;
	assign row_now  = wrap ? row_q + ROW_W'(1) : row_q;
	assign row_m1   = row_now - ROW_W'(1);
	assign row_m2   = row_now - ROW_W'(2);
	assign in_frame = row_now < h_eff;
	assign ignore   = in_frame && (operation == OP_DRAIN);
	assign pix      = in_frame ? pixel_t'({red_in, green_in, blue_in}) : '0;
	assign col_zero = col_now == '0;
	assign row_ge1  = row_now != '0;
	assign row_ge2  = row_now >= ROW_W'(2);
	assign eor      = col_zero && row_ge2;
	assign eor_last = eor && (row_m1 >= h_eff);
	assign blur_e   = row_m2 < blur_x;
	assign blur_c   = row_m1 < blur_x;
	assign cur      = !col_zero && row_ge1;
	assign top_ok   = row_ge2 && (row_m2 < h_eff);
	assign mid_ok   = row_ge1 && (row_m1 < h_eff);
	assign end_row  = (EW'(col_now) + EW'(1)) >= w_eff;

	// pipeline handshake
	logic in_acc;
	logic load1;
	logic move1;
	logic load2;
	logic adv3;
	logic res1;

	logic   valid_s1;
	logic   eor_s1;
	logic   last_s1;
	logic   cur_s1;
	logic   blur_e_s1;
	logic   blur_c_s1;
	logic   col_zero_s1;
	logic   top_ok_s1;
	logic   mid_ok_s1;
	logic   bank_s1;
	pixel_t pix_s1;

	ctrl_t  ctrl_s2;
	pixel_t centre_s2;

	assign adv3     = !out_valid || !out_stall;
	assign load2    = !ctrl_s2.valid || adv3;
	assign res1     = eor_s1 || cur_s1;
	assign move1    = valid_s1 && (!res1 || load2);
	assign load1    = !valid_s1 || move1;
	assign in_stall = !load1;
	assign in_acc   = in_valid && load1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (ignore) begin
				col_q <= col_now;
				row_q <= row_now;
			end else if (eor_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (end_row) begin
				col_q <= '0;
				row_q <= row_now + ROW_W'(1);
			end else begin
				col_q <= col_now + CW'(1);
				row_q <= row_now;
			end
		end
	end

	// line store
	pixel_t rd0;
	pixel_t rd1;

	bbr_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (CW)
	) u_line_store (
		.clk      (clk),
		.rd_en    (in_acc && !ignore),
		.wr_en    (in_acc && !ignore && !eor_last),
		.wr_bank  (row_now[0]),
		.addr     (col_now),
		.wr_data  (pix),
		.rd_data0 (rd0),
		.rd_data1 (rd1)
	);

	// stage 1: window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load1) begin
			valid_s1 <= in_acc && !ignore;
		end
	end

	always_ff @(posedge clk) begin
		if (load1 && in_acc) begin
			eor_s1      <= eor;
			last_s1     <= eor_last;
			cur_s1      <= cur;
			blur_e_s1   <= blur_e;
			blur_c_s1   <= blur_c;
			col_zero_s1 <= col_zero;
			top_ok_s1   <= top_ok;
			mid_ok_s1   <= mid_ok;
			bank_s1     <= row_now[0];
			pix_s1      <= pix;
		end
	end

	pixel_t win_q   [3][3];
	pixel_t win_new [3][3];
	pixel_t win_sel [3][3];
	pixel_t top_px;
	pixel_t mid_px;

	assign top_px = top_ok_s1 ? (bank_s1 ? rd1 : rd0) : '0;
	assign mid_px = mid_ok_s1 ? (bank_s1 ? rd0 : rd1) : '0;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_new[r][0] = col_zero_s1 ? '0 : win_q[r][1];
			win_new[r][1] = col_zero_s1 ? '0 : win_q[r][2];
			win_sel[r][0] = eor_s1 ? win_q[r][1] : win_new[r][0];
			win_sel[r][1] = eor_s1 ? win_q[r][2] : win_new[r][1];
		end
		win_new[0][2] = top_px;
		win_new[1][2] = mid_px;
		win_new[2][2] = pix_s1;
		for (int r = 0; r < 3; r++) begin
			win_sel[r][2] = eor_s1 ? '0 : win_new[r][2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '{default: '0};
		end else if (move1) begin
			if (last_s1) begin
				win_q <= '{default: '0};
			end else begin
				win_q <= win_new;
			end
		end
	end

	// stage 2: lane sums
	logic [CHAN_W-1:0] taps_red   [TAPS];
	logic [CHAN_W-1:0] taps_green [TAPS];
	logic [CHAN_W-1:0] taps_blue  [TAPS];
	logic [CHAN_W-1:0] mean_red;
	logic [CHAN_W-1:0] mean_green;
	logic [CHAN_W-1:0] mean_blue;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				taps_red[r*3+c]   = win_sel[r][c].red;
				taps_green[r*3+c] = win_sel[r][c].green;
				taps_blue[r*3+c]  = win_sel[r][c].blue;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (load2) begin
			ctrl_s2.valid <= valid_s1 && res1;
			ctrl_s2.blur  <= eor_s1 ? blur_e_s1 : blur_c_s1;
			ctrl_s2.last  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			centre_s2 <= win_sel[1][1];
		end
	end

	bbr_lane u_lane_red (
		.clk  (clk),
		.en   (load2),
		.taps (taps_red),
		.mean (mean_red)
	);

	bbr_lane u_lane_green (
		.clk  (clk),
		.en   (load2),
		.taps (taps_green),
		.mean (mean_green)
	);

	bbr_lane u_lane_blue (
		.clk  (clk),
		.en   (load2),
		.taps (taps_blue),
		.mean (mean_blue)
	);

	// stage 3: merge and output
	pixel_t out_px;

	bbr_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv3),
		.ctrl_s2    (ctrl_s2),
		.centre_s2  (centre_s2),
		.mean_red   (mean_red),
		.mean_green (mean_green),
		.mean_blue  (mean_blue),
		.valid      (out_valid),
		.pixel      (out_px),
		.last       (frame_end)
	);

	assign red_out   = out_px.red;
	assign green_out = out_px.green;
	assign blue_out  = out_px.blue;

endmodule
`default_nettype wire

/* src/bbr_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_line_store - two-row line buffer
// One bank per row parity. Both banks are read at the same column, one bank
// is written; a read returns the contents from before the same-edge write.
// ----------------------------------------------------------------------------
module bbr_line_store #(
	parameter int MAX_WIDTH = bbr_pkg::DEFAULT_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  wire logic                 clk,
	input  wire logic                 rd_en,
	input  wire logic                 wr_en,
	input  wire logic                 wr_bank,
	input  wire logic [COL_W-1:0]     addr,
	input  wire bbr_pkg::pixel_t      wr_data,
	output bbr_pkg::pixel_t           rd_data0,
	output bbr_pkg::pixel_t           rd_data1
);
	import bbr_pkg::*;

	pixel_t bank0_q [MAX_WIDTH];
	pixel_t bank1_q [MAX_WIDTH];
	pixel_t rd0_q;
	pixel_t rd1_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd0_q <= bank0_q[addr];
			rd1_q <= bank1_q[addr];
		end
		if (wr_en && !wr_bank) begin
			bank0_q[addr] <= wr_data;
		end
		if (wr_en && wr_bank) begin
			bank1_q[addr] <= wr_data;
		end
	end

	assign rd_data0 = rd0_q;
	assign rd_data1 = rd1_q;

endmodule
`default_nettype wire

/* src/bbr_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_lane - one colour channel of the blur
// Registers the sum of the nine window taps, then divides it by nine with a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module bbr_lane (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [bbr_pkg::CHAN_W-1:0]  taps [bbr_pkg::TAPS],
	output logic      [bbr_pkg::CHAN_W-1:0]  mean
);
	import bbr_pkg::*;

	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   sum_s2;
	logic [2*SUM_W-1:0] prod;

	always_comb begin
		sum = '0;
		for (int i = 0; i < TAPS; i++) begin
			sum = sum + SUM_W'(taps[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum;
		end
	end

	assign prod = sum_s2 * RECIP;
	assign mean = prod[RECIP_SHIFT +: CHAN_W];

endmodule
`default_nettype wire

/* src/bbr_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_merge - output stage
// Combines the three lane results into one pixel, or passes the centre pixel
// on rows below the blur band, and holds it for the output transfer.
// ----------------------------------------------------------------------------
module bbr_merge (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire bbr_pkg::ctrl_t             ctrl_s2,
	input  wire bbr_pkg::pixel_t            centre_s2,
	input  wire logic [bbr_pkg::CHAN_W-1:0] mean_red,
	input  wire logic [bbr_pkg::CHAN_W-1:0] mean_green,
	input  wire logic [bbr_pkg::CHAN_W-1:0] mean_blue,
	output logic                            valid,
	output bbr_pkg::pixel_t                 pixel,
	output logic                            last
);
	import bbr_pkg::*;

	logic   valid_s3;
	pixel_t pixel_s3;
	logic   last_s3;
	pixel_t blurred;

	assign blurred = '{red: mean_red, green: mean_green, blue: mean_blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s3 <= ctrl_s2.blur ? blurred : centre_s2;
			last_s3  <= ctrl_s2.last;
		end
	end

	assign valid = valid_s3;
	assign pixel = pixel_s3;
	assign last  = last_s3;

endmodule
`default_nettype wire

/* verif/box_blur_3x3_rgb_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_tb - self-checking bench for the 3x3 RGB box blur
// Streams raster frames of many sizes through the block under random idling
// on both channels. A scoreboard predicts every output pixel from the
// accepted transfers and checks each one as it leaves the block.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_tb;
	import bbr_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int MAX_W          = DEFAULT_MAX_WIDTH;
	localparam int RANDOM_ITEMS   = 950;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	typedef struct packed {
		pixel_t px;
		logic   last;
	} blur_result_t;

	class blur_scoreboard;
		pixel_t             line_mem [2*MAX_W];
		pixel_t             win [TAPS];
		pixel_t             taps [TAPS];
		int unsigned        in_col;
		int unsigned        in_row;
		logic [IMG_W_W-1:0] width_reg;
		logic [IMG_H_W-1:0] height_reg;
		logic [BLUR_W-1:0]  blur_reg;
		blur_result_t       due_pixels [$];
		int                 errors;

		function new();
			foreach (line_mem[i]) line_mem[i] = '0;
			clear_positions();
			width_reg  = IMG_W_RESET;
			height_reg = IMG_H_RESET;
			blur_reg   = BLUR_RESET;
			errors     = 0;
		endfunction

		function void clear_positions();
			foreach (win[i]) win[i] = '0;
			in_col = 0;
			in_row = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return int'(width_reg);
		endfunction

		function int unsigned eff_height();
			return (height_reg == 0) ? 1 : int'(height_reg);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_IMAGE_WIDTH:  width_reg  = data[IMG_W_W-1:0];
				CFG_IMAGE_HEIGHT: height_reg = data[IMG_H_W-1:0];
				CFG_BLUR_ROWS:    blur_reg   = data[BLUR_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_pixels.size();
		endfunction

		function bit frame_open();
			return (in_col != 0) || (in_row != 0);
		endfunction

		function bit pixels_due();
			int unsigned next_row;
			next_row = (in_col >= eff_width()) ? in_row + 1 : in_row;
			return next_row < eff_height();
		endfunction

		function blur_result_t form_pixel(int unsigned orow, bit last);
			blur_result_t res;
			int unsigned  rs, gs, bs;
			rs = 0;
			gs = 0;
			bs = 0;
			res.px = taps[4];
			if (orow < blur_reg) begin
				foreach (taps[i]) begin
					rs += taps[i].red;
					gs += taps[i].green;
					bs += taps[i].blue;
				end
				res.px.red   = 8'(rs / TAPS);
				res.px.green = 8'(gs / TAPS);
				res.px.blue  = 8'(bs / TAPS);
			end
			res.last = last;
			return res;
		endfunction

		function void note_transfer(logic op, pixel_t px);
			int unsigned w, h, ic, ir;
			pixel_t      pix, top, mid;
			bit          closing;
			w   = eff_width();
			h   = eff_height();
			pix = '0;
			top = '0;
			mid = '0;
			if (in_col >= w || in_col >= MAX_W) begin
				in_col = 0;
				in_row++;
			end
			ic = in_col;
			ir = in_row;
			if (ir < h) begin
				if (op == OP_DRAIN) return;
				pix = px;
			end
			// last column of the row two above leaves as a new row starts
			if (ic == 0 && ir >= 2) begin
				for (int r = 0; r < 3; r++) begin
					taps[r*3]   = win[r*3+1];
					taps[r*3+1] = win[r*3+2];
					taps[r*3+2] = '0;
				end
				closing = (ir - 1 >= h);
				due_pixels.push_back(form_pixel(ir - 2, closing));
				if (closing) begin
					clear_positions();
					return;
				end
			end
			if (ir >= 2 && ir - 2 < h) top = line_mem[(ir & 1) * MAX_W + ic];
			if (ir >= 1 && ir - 1 < h) mid = line_mem[((ir + 1) & 1) * MAX_W + ic];
			line_mem[(ir & 1) * MAX_W + ic] = pix;
			for (int r = 0; r < 3; r++) begin
				if (ic == 0) begin
					win[r*3]   = '0;
					win[r*3+1] = '0;
				end else begin
					win[r*3]   = win[r*3+1];
					win[r*3+1] = win[r*3+2];
				end
			end
			win[2] = top;
			win[5] = mid;
			win[8] = pix;
			if (ic >= 1 && ir >= 1) begin
				taps = win;
				due_pixels.push_back(form_pixel(ir - 1, 1'b0));
			end
			if (ic + 1 >= w) begin
				in_col = 0;
				in_row = ir + 1;
			end else begin
				in_col = ic + 1;
			end
		endfunction

		function void compare_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(pixel_t got, logic got_last);
			blur_result_t want;
			if (due_pixels.size() == 0) begin
				errors++;
				$display("%0t unexpected output: expected none, actual %h last %b",
					$time, got, got_last);
				return;
			end
			want = due_pixels.pop_front();
			compare_field("red_out", want.px.red, got.red);
			compare_field("green_out", want.px.green, got.green);
			compare_field("blue_out", want.px.blue, got.blue);
			compare_field("frame_end", CHAN_W'(want.last), CHAN_W'(got_last));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  operation;
	logic [CHAN_W-1:0]     red_in, green_in, blue_in;
	logic                  out_valid;
	logic                  out_stall;
	logic [CHAN_W-1:0]     red_out, green_out, blue_out;
	logic                  frame_end;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	blur_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int stim_count;
	int stuck_cycles;

	box_blur_3x3_rgb uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic pixel_t random_pixel();
		logic [3*CHAN_W-1:0] v;
		v = (3*CHAN_W)'($urandom());
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_item(input logic op, input pixel_t px);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		red_in    <= px.red;
		green_in  <= px.green;
		blue_in   <= px.blue;
		do @(posedge clk); while (in_stall);
		board.note_transfer(op, px);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		board.set_reg(idx, data);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, h, b);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_BLUR_ROWS, b);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// hold the sender until every due pixel is out and the pipeline is empty
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// finish the current frame: remaining pixels, then flush transfers
	task automatic run_frame();
		while (board.pixels_due()) begin
			if ($urandom_range(0, 99) < 4) send_item(OP_DRAIN, random_pixel());
			send_item(OP_PIXEL, random_pixel());
			stim_count++;
		end
		do begin
			send_item(($urandom_range(0, 2) == 0) ? OP_PIXEL : OP_DRAIN, random_pixel());
			stim_count++;
		end while (board.frame_open());
		if ($urandom_range(0, 3) == 0) send_item(OP_DRAIN, random_pixel());
	endtask

	task automatic set_profile();
		if (stim_count < RANDOM_ITEMS / 3) begin
			send_idle_pct = 21;
			recv_idle_pct = 60;
		end else if (stim_count < 2 * RANDOM_ITEMS / 3) begin
			send_idle_pct = 60;
			recv_idle_pct = 21;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk)
		if (out_valid && !out_stall)
			board.check_result('{red: red_out, green: green_out, blue: blue_out}, frame_end);

	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("box_blur_3x3_rgb_tb NOT OK");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0] w, h, b;
		board         = new();
		send_idle_pct = 21;
		recv_idle_pct = 60;
		hold_left     = 0;
		stim_count    = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = OP_PIXEL;
		red_in        = '0;
		green_in      = '0;
		blue_in       = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = CFG_IMAGE_WIDTH;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// saturated frame with ignored drains and a pixel after the frame
		configure(13'd3, 13'd3, 13'd2);
		send_item(OP_DRAIN, random_pixel());
		repeat (4) send_item(OP_PIXEL, '1);
		send_item(OP_DRAIN, '0);
		repeat (5) send_item(OP_PIXEL, '1);
		send_item(OP_PIXEL, pixel_t'(24'hA5C35A));
		run_frame();

		// narrow the frame part way through a row
		wait_quiet();
		configure(13'd4, 13'd2, 13'd1);
		send_item(OP_PIXEL, '0);
		send_item(OP_PIXEL, '{red: 8'h80, green: 8'h7F, blue: 8'h01});
		send_item(OP_PIXEL, '{red: 8'hFE, green: 8'h01, blue: 8'h80});
		wait_quiet();
		write_reg(CFG_SPARE_IDX, 13'h1ABC);
		configure(13'd2, 13'd2, 13'd0);
		run_frame();

		stim_count = 0;
		while (stim_count < RANDOM_ITEMS) begin
			wait_quiet();
			set_profile();
			w = CFG_DATA_W'($urandom_range(0, 9));
			h = CFG_DATA_W'($urandom_range(0, 6));
			b = CFG_DATA_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) :
				$urandom_range(0, 8));
			configure(w, h, b);
			repeat ($urandom_range(1, 3)) run_frame();
		end

		// every row blurred, under a long output hold
		wait_quiet();
		configure(13'd9, 13'd6, 13'd8191);
		hold_left = LONG_HOLD;
		run_frame();

		// tall narrow frame, upper rows blurred
		wait_quiet();
		configure(13'd1, 13'd64, 13'd40);
		run_frame();

		wait_quiet();
		if (board.errors == 0)
			$display("box_blur_3x3_rgb_tb OK");
		else
			$display("box_blur_3x3_rgb_tb NOT OK");
		$finish;
	end

endmodule
